// ===== hw/rtl/chrl_pkg.sv =====
// ----------------------------------------------------------------------------
// chrl_pkg: shared types and constants for the hash ring lookup
// Field widths, function and status codes, and the sequencer status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package chrl_pkg;

  // Fixed field widths
  localparam int FUNC_W   = 1;
  localparam int SLOT_W   = 10;
  localparam int POINT_W  = 32;
  localparam int INDEX_W  = 10;
  localparam int CFG_W    = 11;
  localparam int STATUS_W = 1;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 1'b0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 1'b1;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic busy;  // a request is in progress
    logic done;  // a result is waiting to be moved to the output register
  } seq_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/chrl_ring_mem.sv =====
// ----------------------------------------------------------------------------
// chrl_ring_mem: ring entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module chrl_ring_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 40
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry, data valid the next cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/chrl_search_seq.sv =====
// ----------------------------------------------------------------------------
// chrl_search_seq: load and lower-bound search sequencer
// Writes loaded entries and runs the binary search over the ring memory,
// each probe a read and then a compare, on a single shared magnitude comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module chrl_search_seq #(
  parameter int RING_DEPTH   = 1024,
  parameter int NODE_ID_BITS = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [chrl_pkg::FUNC_W-1:0]          func,
  input  wire logic [chrl_pkg::SLOT_W-1:0]          entry_slot,
  input  wire logic [chrl_pkg::POINT_W-1:0]         entry_point,
  input  wire logic [NODE_ID_BITS-1:0]              entry_node,
  input  wire logic [chrl_pkg::POINT_W-1:0]         key_hash,
  input  wire logic [chrl_pkg::CFG_W-1:0]           ring_entries,
  input  wire logic                                 take,
  output chrl_pkg::seq_stat_t                       stat,
  output logic      [NODE_ID_BITS-1:0]              res_node,
  output logic      [chrl_pkg::INDEX_W-1:0]         res_index,
  output logic      [chrl_pkg::STATUS_W-1:0]        res_status,
  output logic                                      mem_we,
  output logic      [$clog2(RING_DEPTH)-1:0]        mem_waddr,
  output logic      [chrl_pkg::POINT_W+NODE_ID_BITS-1:0] mem_wdata,
  output logic                                      mem_re,
  output logic      [$clog2(RING_DEPTH)-1:0]        mem_raddr,
  input  wire logic [chrl_pkg::POINT_W+NODE_ID_BITS-1:0] mem_rdata
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int NW = $clog2(RING_DEPTH + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_NODE  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                         state, state_next;
  logic [NW-1:0]                      lo, lo_next;
  logic [NW-1:0]                      hi, hi_next;
  logic [NW-1:0]                      mid, mid_next;
  logic [NW-1:0]                      used, used_next;
  logic [chrl_pkg::POINT_W-1:0]       hash, hash_next;
  logic [NODE_ID_BITS-1:0]            res_node_next;
  logic [chrl_pkg::INDEX_W-1:0]       res_index_next;
  logic [chrl_pkg::STATUS_W-1:0]      res_status_next;

  logic [NW-1:0]                      cfg_used;
  logic [NW-1:0]                      probe_mid;
  logic [NW-1:0]                      final_idx;
  logic [chrl_pkg::POINT_W-1:0]       cmp_a;
  logic [chrl_pkg::POINT_W-1:0]       cmp_b;
  logic                               cmp_lt;
  logic [chrl_pkg::POINT_W-1:0]       rd_point;
  logic [NODE_ID_BITS-1:0]            rd_node;

  // Saturate the entry count to the memory depth
  assign cfg_used = (32'(ring_entries) > 32'(RING_DEPTH)) ? NW'(RING_DEPTH)
                                                          : NW'(ring_entries);

  assign probe_mid = lo + ((hi - lo) >> 1);
  assign final_idx = (lo == used) ? '0 : lo;

  assign rd_point = mem_rdata[NODE_ID_BITS +: chrl_pkg::POINT_W];
  assign rd_node  = mem_rdata[NODE_ID_BITS-1:0];

  // Shared comparator: bounds check while probing, point against hash after a read
  always_comb begin
    if (state == S_CMP) begin
      cmp_a = rd_point;
      cmp_b = hash;
    end else begin
      cmp_a = 32'(lo);
      cmp_b = 32'(hi);
    end
  end

  assign cmp_lt = cmp_a < cmp_b;

  // Sequencer
  always_comb begin
    state_next      = state;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    used_next       = used;
    hash_next       = hash;
    res_node_next   = res_node;
    res_index_next  = res_index;
    res_status_next = res_status;
    mem_we          = 1'b0;
    mem_waddr       = AW'(entry_slot);
    mem_wdata       = {entry_point, entry_node};
    mem_re          = 1'b0;
    mem_raddr       = AW'(probe_mid);

    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (func == chrl_pkg::FUNC_LOAD) begin
            // Drop writes beyond the memory, still report the slot
            mem_we          = 32'(entry_slot) < 32'(RING_DEPTH);
            res_node_next   = '0;
            res_index_next  = entry_slot;
            res_status_next = chrl_pkg::STATUS_OK;
            state_next      = S_DONE;
          end else if (cfg_used == '0) begin
            res_node_next   = '0;
            res_index_next  = '0;
            res_status_next = chrl_pkg::STATUS_EMPTY;
            state_next      = S_DONE;
          end else begin
            lo_next         = '0;
            hi_next         = cfg_used;
            used_next       = cfg_used;
            hash_next       = key_hash;
            res_status_next = chrl_pkg::STATUS_OK;
            state_next      = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        mem_re = 1'b1;
        if (cmp_lt) begin
          // Read the midpoint of the remaining range
          mid_next   = probe_mid;
          state_next = S_CMP;
        end else begin
          // Range closed: fetch the chosen entry, wrapping to entry 0
          mem_raddr      = AW'(final_idx);
          res_index_next = chrl_pkg::INDEX_W'(final_idx);
          state_next     = S_NODE;
        end
      end
      S_CMP: begin
        if (cmp_lt) begin
          lo_next = mid + 1'b1;
        end else begin
          hi_next = mid;
        end
        state_next = S_PROBE;
      end
      S_NODE: begin
        res_node_next = rd_node;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    used       <= used_next;
    hash       <= hash_next;
    res_node   <= res_node_next;
    res_index  <= res_index_next;
    res_status <= res_status_next;
  end

  assign stat = '{busy: (state != S_IDLE), done: (state == S_DONE)};

endmodule

`default_nettype wire

// ===== hw/rtl/consistent_hash_ring_lookup_top.sv =====
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup_top: consistent hash ring lookup
// Loads sorted ring entries and places key hashes on the ring.
// ----------------------------------------------------------------------------
// One request is worked at a time; in_stall is high from acceptance until the
// result has moved into the output register, which then holds it for the
// consumer while the next request is taken. A load or an empty-ring lookup
// goes from idle straight to the done state and from there into the output
// register. Each binary search probe of a lookup is one read of the ring
// memory through its registered read port, followed by the shared compare.
// ring_entries above RING_DEPTH is treated as RING_DEPTH. Entries must be
// loaded in ascending point order; a lookup that reaches a slot never loaded
// returns undefined node data. Configuration writes are always taken but must
// only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module consistent_hash_ring_lookup_top #(
  parameter int RING_DEPTH   = 1024,
  parameter int NODE_ID_BITS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [chrl_pkg::CFG_W-1:0]          cfg_data,
  // Request channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [chrl_pkg::FUNC_W-1:0]         func,
  input  wire logic [chrl_pkg::SLOT_W-1:0]         entry_slot,
  input  wire logic [chrl_pkg::POINT_W-1:0]        entry_point,
  input  wire logic [NODE_ID_BITS-1:0]             entry_node,
  input  wire logic [chrl_pkg::POINT_W-1:0]        key_hash,
  // Result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [NODE_ID_BITS-1:0]             node_id,
  output logic      [chrl_pkg::INDEX_W-1:0]        ring_index,
  output logic      [chrl_pkg::STATUS_W-1:0]       status
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int MW = chrl_pkg::POINT_W + NODE_ID_BITS;

  logic [chrl_pkg::CFG_W-1:0]    ring_entries;
  chrl_pkg::seq_stat_t           stat;
  logic                          start;
  logic                          take;
  logic [NODE_ID_BITS-1:0]       res_node;
  logic [chrl_pkg::INDEX_W-1:0]  res_index;
  logic [chrl_pkg::STATUS_W-1:0] res_status;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [MW-1:0]                 mem_wdata;
  logic                          mem_re;
  logic [AW-1:0]                 mem_raddr;
  logic [MW-1:0]                 mem_rdata;

  // Entry count register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_entries <= '0;
    end else if (cfg_valid && cfg_ready) begin
      ring_entries <= cfg_data;
    end
  end

  // Request handshake
  assign in_stall = stat.busy;
  assign start    = in_valid && !in_stall;

  // Move a finished result into the output register when it is free
  assign take = stat.done && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      node_id    <= res_node;
      ring_index <= res_index;
      status     <= res_status;
    end
  end

  chrl_search_seq #(
    .RING_DEPTH  (RING_DEPTH),
    .NODE_ID_BITS(NODE_ID_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .func        (func),
    .entry_slot  (entry_slot),
    .entry_point (entry_point),
    .entry_node  (entry_node),
    .key_hash    (key_hash),
    .ring_entries(ring_entries),
    .take        (take),
    .stat        (stat),
    .res_node    (res_node),
    .res_index   (res_index),
    .res_status  (res_status),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  chrl_ring_mem #(
    .DEPTH(RING_DEPTH),
    .WIDTH(MW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/chrl_checker.sv =====
// ----------------------------------------------------------------------------
// chrl_checker: port-level checks for the hash ring lookup
// Watches the request and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module chrl_checker #(
  parameter int NODE_ID_BITS = 8
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [NODE_ID_BITS-1:0]       node_id,
  input wire logic [chrl_pkg::INDEX_W-1:0]  ring_index,
  input wire logic [chrl_pkg::STATUS_W-1:0] status
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(node_id) &&
                               $stable(ring_index) && $stable(status))
    else $error("stalled result changed");

  // Block further requests right after one is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in progress");

  // Report an empty ring with node 0 and index 0
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == chrl_pkg::STATUS_EMPTY) |-> node_id == '0 && ring_index == '0)
    else $error("empty ring result carries data");

  // Come out of reset with no result and ready for a request
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind consistent_hash_ring_lookup_top chrl_checker #(
  .NODE_ID_BITS(NODE_ID_BITS)
) u_chrl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .node_id   (node_id),
  .ring_index(ring_index),
  .status    (status)
);

`default_nettype wire
